// File: design/ptpd_pkg.sv
// Package for the pan/tilt PD tracker: register indexes, reset values,
// fixed image constants and the per-axis result type. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ptpd_pkg;

   // Configuration register indexes.
   localparam logic [3:0] CSR_PAN_P_GAIN      = 4'd0;
   localparam logic [3:0] CSR_TILT_P_GAIN     = 4'd1;
   localparam logic [3:0] CSR_PAN_D_GAIN      = 4'd2;
   localparam logic [3:0] CSR_TILT_D_GAIN     = 4'd3;
   localparam logic [3:0] CSR_PAN_LOW_LIMIT   = 4'd4;
   localparam logic [3:0] CSR_PAN_HIGH_LIMIT  = 4'd5;
   localparam logic [3:0] CSR_TILT_LOW_LIMIT  = 4'd6;
   localparam logic [3:0] CSR_TILT_HIGH_LIMIT = 4'd7;

   // Image center and dead zone, in whole pixels.
   localparam logic [12:0] CENTER_X     = 13'd320;
   localparam logic [12:0] CENTER_Y     = 13'd240;
   localparam logic [12:0] DEAD_ZONE_PX = 13'd10;

   // Reset values, angles in 1/256 degree.
   localparam logic [15:0] HELD_RESET            = 16'd23040;
   localparam logic [15:0] PAN_LOW_LIMIT_RESET   = 16'd0;
   localparam logic [15:0] PAN_HIGH_LIMIT_RESET  = 16'd46080;
   localparam logic [15:0] TILT_LOW_LIMIT_RESET  = 16'd7680;
   localparam logic [15:0] TILT_HIGH_LIMIT_RESET = 16'd38400;

   typedef struct packed {
      logic [15:0]        angle;
      logic               at_limit;
      logic signed [12:0] err;
   } axis_result_type;

endpackage

`default_nettype wire

// File: design/pan_tilt_pd_tracker.sv
// Two-axis PD pan/tilt tracker with dead zone, one update per beat.
// Depends on ptpd_pkg.
//
// Each request beat carries a target pixel position and a tracking flag and
// yields exactly one response beat with the commanded pan and tilt angles
// (1/256 degree) and their at-limit flags. A beat is captured in an input
// register, the whole PD update for both axes is done combinationally from it
// and lands in the output register, so the block sustains one beat per clock
// while responses are taken; the held angles and last errors, registered
// alongside, feed the next beat. With tracking low the stored errors
// are cleared and the held angles are returned unclamped with both flags low.
// Gains are signed Q4.12, the update is (err*P + (err-last)*D) >>> 4, and the
// new angle is clamped to the configured limits. Configuration writes are
// always accepted and should be issued only while the block is idle.
`timescale 1ns / 1ps
`default_nettype none

module pan_tilt_pd_tracker
   import ptpd_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   // Request stream.
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [23:0] req_tdata,   // x position [11:0], y position [23:12]
   input  wire logic        req_tuser,   // tracking [0]
   // Response stream.
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [39:0]      rsp_tdata,   // pan_angle [15:0], tilt_angle [31:16],
                                         // pan clamped [32], tilt clamped [33],
                                         // zero [39:34]
   // Configuration writes.
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [3:0]  csr_index,
   input  wire logic [15:0] csr_data
);

   logic signed [15:0] pan_p_gain_ff, tilt_p_gain_ff, pan_d_gain_ff, tilt_d_gain_ff;
   logic [15:0]        pan_low_ff, pan_high_ff, tilt_low_ff, tilt_high_ff;

   logic               in_valid_ff;
   logic               tracking_ff;
   logic [11:0]        aim_x_ff, aim_y_ff;

   logic [15:0]        held_pan_ff, held_pan_in;
   logic [15:0]        held_tilt_ff, held_tilt_in;
   logic signed [12:0] last_err_x_ff, last_err_x_in;
   logic signed [12:0] last_err_y_ff, last_err_y_in;

   logic               out_valid_ff;
   logic [39:0]        out_data_ff, out_data_in;

   logic               advance;
   axis_result_type    pan_res, tilt_res;
   logic               pan_flag, tilt_flag;

   function automatic axis_result_type axis_update(
      input logic [11:0]        pos,
      input logic [12:0]        center,
      input logic signed [15:0] kp,
      input logic signed [15:0] kd,
      input logic [15:0]        lo,
      input logic [15:0]        hi,
      input logic [15:0]        held,
      input logic signed [12:0] last
   );
      logic signed [12:0] err;
      logic [12:0]        mag;
      logic signed [13:0] diff;
      logic signed [28:0] prod_p;
      logic signed [29:0] prod_d;
      logic signed [30:0] total;
      logic signed [26:0] change;
      logic signed [27:0] sum;
      logic signed [27:0] lo_s;
      logic signed [27:0] hi_s;
      logic signed [27:0] clamped;
      axis_result_type    r;
      err = $signed({1'b0, pos}) - $signed(center);
      mag = err[12] ? 13'(-err) : 13'(err);
      if (mag <= DEAD_ZONE_PX) begin
         err = '0;
      end
      diff   = 14'(err) - 14'(last);
      prod_p = 29'(err) * 29'(kp);
      prod_d = 30'(diff) * 30'(kd);
      total  = 31'(prod_p) + 31'(prod_d);
      // Arithmetic shift rounds toward minus infinity.
      change = 27'(total >>> 4);
      sum    = 28'($signed({1'b0, held})) + 28'(change);
      lo_s   = $signed({12'd0, lo});
      hi_s   = $signed({12'd0, hi});
      priority if (sum < lo_s) begin
         clamped = lo_s;
      end else if (sum > hi_s) begin
         clamped = hi_s;
      end else begin
         clamped = sum;
      end
      r.angle    = clamped[15:0];
      r.at_limit = (clamped != sum);
      r.err      = err;
      return r;
   endfunction

   // The input register moves on whenever the output register is free or drained.
   assign advance    = !out_valid_ff || rsp_tready;
   assign req_tready = !in_valid_ff || advance;
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

   always_comb begin
      pan_res  = axis_update(aim_x_ff, CENTER_X, pan_p_gain_ff, pan_d_gain_ff,
                             pan_low_ff, pan_high_ff, held_pan_ff, last_err_x_ff);
      tilt_res = axis_update(aim_y_ff, CENTER_Y, tilt_p_gain_ff, tilt_d_gain_ff,
                             tilt_low_ff, tilt_high_ff, held_tilt_ff, last_err_y_ff);
      if (tracking_ff) begin
         held_pan_in   = pan_res.angle;
         held_tilt_in  = tilt_res.angle;
         last_err_x_in = pan_res.err;
         last_err_y_in = tilt_res.err;
         pan_flag      = pan_res.at_limit;
         tilt_flag     = tilt_res.at_limit;
      end else begin
         held_pan_in   = held_pan_ff;
         held_tilt_in  = held_tilt_ff;
         last_err_x_in = '0;
         last_err_y_in = '0;
         pan_flag      = 1'b0;
         tilt_flag     = 1'b0;
      end
      out_data_in = {6'd0, tilt_flag, pan_flag, held_tilt_in, held_pan_in};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pan_p_gain_ff  <= '0;
         tilt_p_gain_ff <= '0;
         pan_d_gain_ff  <= '0;
         tilt_d_gain_ff <= '0;
         pan_low_ff     <= PAN_LOW_LIMIT_RESET;
         pan_high_ff    <= PAN_HIGH_LIMIT_RESET;
         tilt_low_ff    <= TILT_LOW_LIMIT_RESET;
         tilt_high_ff   <= TILT_HIGH_LIMIT_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_PAN_P_GAIN:      pan_p_gain_ff  <= $signed(csr_data);
            CSR_TILT_P_GAIN:     tilt_p_gain_ff <= $signed(csr_data);
            CSR_PAN_D_GAIN:      pan_d_gain_ff  <= $signed(csr_data);
            CSR_TILT_D_GAIN:     tilt_d_gain_ff <= $signed(csr_data);
            CSR_PAN_LOW_LIMIT:   pan_low_ff     <= csr_data;
            CSR_PAN_HIGH_LIMIT:  pan_high_ff    <= csr_data;
            CSR_TILT_LOW_LIMIT:  tilt_low_ff    <= csr_data;
            CSR_TILT_HIGH_LIMIT: tilt_high_ff   <= csr_data;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         out_valid_ff  <= 1'b0;
         held_pan_ff   <= HELD_RESET;
         held_tilt_ff  <= HELD_RESET;
         last_err_x_ff <= '0;
         last_err_y_ff <= '0;
      end else begin
         if (req_tready) begin
            in_valid_ff <= req_tvalid;
         end
         if (advance) begin
            out_valid_ff <= in_valid_ff;
         end
         if (advance && in_valid_ff) begin
            held_pan_ff   <= held_pan_in;
            held_tilt_ff  <= held_tilt_in;
            last_err_x_ff <= last_err_x_in;
            last_err_y_ff <= last_err_y_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         tracking_ff <= req_tuser;
         aim_x_ff    <= req_tdata[11:0];
         aim_y_ff    <= req_tdata[23:12];
      end
      if (advance && in_valid_ff) begin
         out_data_ff <= out_data_in;
      end
   end

endmodule

`default_nettype wire

// File: design/ptpd_checker.sv
// Port-level checker for the pan/tilt PD tracker and its bind statement.
// Depends on pan_tilt_pd_tracker.
`timescale 1ns / 1ps
`default_nettype none

module ptpd_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tvalid,
   input wire logic        req_tready,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [39:0] rsp_tdata
);

   // A stalled response beat keeps its payload.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled response beat changed");

   // Reset empties the output register.
   assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("response valid after reset");

   // With nothing waiting at the output, a request beat is always taken.
   assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("request stalled with empty output");

   // An accepted beat passes through the input register into the output register unless the output stalls.
   assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) ##1 !(rsp_tvalid && !rsp_tready) |=> rsp_tvalid)
      else $error("accepted beat did not reach the output");

   // Padding bits of the response stay zero.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[39:34] == 6'd0)
      else $error("response padding not zero");

endmodule

bind pan_tilt_pd_tracker ptpd_checker u_ptpd_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

`default_nettype wire

// File: sim/testbench.sv
// Self-checking testbench for the pan/tilt PD tracker: a clocked driver and
// monitor, an in-bench servo predictor and randomized register settings.
// Depends on ptpd_pkg and pan_tilt_pd_tracker.
`timescale 1ns / 1ps

module testbench;
   import ptpd_pkg::*;

   typedef struct {
      logic        tracking;
      logic [11:0] x;
      logic [11:0] y;
   } frame_type;

   typedef struct {
      logic [15:0] pan;
      logic [15:0] tilt;
      logic        pan_limit;
      logic        tilt_limit;
   } servo_type;

   localparam logic [3:0] CSR_UNUSED_INDEX = 4'd12;
   localparam int         LAST_PHASE       = 8;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata = '0;   // x position [11:0], y position [23:12]
   logic        req_tuser = 1'b0; // tracking [0]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;        // pan_angle [15:0], tilt_angle [31:16],
                                  // pan clamped [32], tilt clamped [33]
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [3:0]  csr_index = '0;
   logic [15:0] csr_data = '0;

   pan_tilt_pd_tracker u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #6 clock = ~clock;

   // Servo state mirrored by the predictor.
   logic [15:0]        cfg_reg [8];
   logic [15:0]        held_pan = HELD_RESET;
   logic [15:0]        held_tilt = HELD_RESET;
   logic signed [12:0] last_err_x = '0;
   logic signed [12:0] last_err_y = '0;

   frame_type frames_pending [$];
   servo_type angles_expected [$];
   frame_type frame_in_flight;

   int idle_pct = 0;
   int req_gap = 0;
   int rsp_gap = 0;
   int errors = 0;
   int n_frames = 0;
   int n_hold = 0;
   int n_results = 0;
   int n_clamped = 0;
   int n_writes = 0;
   int n_settings = 0;
   int wander_x = 320;
   int wander_y = 240;

   task automatic report_mismatch(input string what, input longint want, input longint got);
      $display("[%0t] response %0d: %s expected %0d, got %0d",
               $time, n_results, what, want, got);
      errors++;
   endtask

   function automatic axis_result_type axis_update(
      input logic [11:0] pos, input logic [12:0] center,
      input logic signed [15:0] kp, input logic signed [15:0] kd,
      input logic [15:0] lo, input logic [15:0] hi,
      input logic [15:0] held, input logic signed [12:0] last);
      longint err, acc, sum, clamped, dz;
      axis_result_type r;
      dz = longint'(DEAD_ZONE_PX);
      err = longint'(pos) - longint'(center);
      if (err <= dz && err >= -dz)
         err = 0;
      acc = err * longint'(kp) + (err - longint'(last)) * longint'(kd);
      // Arithmetic shift floors toward minus infinity.
      sum = longint'(held) + (acc >>> 4);
      if (sum < longint'(lo))
         clamped = longint'(lo);
      else if (sum > longint'(hi))
         clamped = longint'(hi);
      else
         clamped = sum;
      r.angle = clamped[15:0];
      r.at_limit = (clamped != sum);
      r.err = err[12:0];
      return r;
   endfunction

   function automatic servo_type predict_servo(input frame_type f);
      axis_result_type pan_r, tilt_r;
      servo_type r;
      r.pan_limit = 1'b0;
      r.tilt_limit = 1'b0;
      if (!f.tracking) begin
         last_err_x = '0;
         last_err_y = '0;
         n_hold++;
      end else begin
         pan_r = axis_update(f.x, CENTER_X, cfg_reg[CSR_PAN_P_GAIN], cfg_reg[CSR_PAN_D_GAIN],
                             cfg_reg[CSR_PAN_LOW_LIMIT], cfg_reg[CSR_PAN_HIGH_LIMIT],
                             held_pan, last_err_x);
         tilt_r = axis_update(f.y, CENTER_Y, cfg_reg[CSR_TILT_P_GAIN],
                              cfg_reg[CSR_TILT_D_GAIN], cfg_reg[CSR_TILT_LOW_LIMIT],
                              cfg_reg[CSR_TILT_HIGH_LIMIT], held_tilt, last_err_y);
         held_pan = pan_r.angle;
         last_err_x = pan_r.err;
         r.pan_limit = pan_r.at_limit;
         held_tilt = tilt_r.angle;
         last_err_y = tilt_r.err;
         r.tilt_limit = tilt_r.at_limit;
      end
      r.pan = held_pan;
      r.tilt = held_tilt;
      return r;
   endfunction

   // Request driver: keeps a beat stable until it is taken, idles in bursts.
   always @(posedge clock) begin
      logic next_valid;
      frame_type f;
      if (reset) begin
         req_tvalid <= 1'b0;
         req_gap = 0;
      end else begin
         next_valid = req_tvalid;
         if (req_tvalid && req_tready) begin
            angles_expected.push_back(predict_servo(frame_in_flight));
            n_frames++;
         end
         if (!req_tvalid || req_tready) begin
            next_valid = 1'b0;
            if (req_gap > 0)
               req_gap--;
            else if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct)
               req_gap = $urandom_range(1, 19) - 1;
            else if (frames_pending.size() > 0) begin
               f = frames_pending.pop_front();
               frame_in_flight = f;
               req_tdata <= {f.y, f.x};
               req_tuser <= f.tracking;
               next_valid = 1'b1;
            end
         end
         req_tvalid <= next_valid;
      end
   end

   // Response monitor with its own random back-pressure.
   always @(posedge clock) begin
      servo_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
         rsp_gap = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            n_results++;
            if (angles_expected.size() == 0) begin
               report_mismatch("unexpected beat, data", 0, rsp_tdata);
            end else begin
               want = angles_expected.pop_front();
               if (rsp_tdata[15:0] != want.pan)
                  report_mismatch("pan_angle", want.pan, rsp_tdata[15:0]);
               if (rsp_tdata[31:16] != want.tilt)
                  report_mismatch("tilt_angle", want.tilt, rsp_tdata[31:16]);
               if (rsp_tdata[32] !== want.pan_limit)
                  report_mismatch("pan clamped", want.pan_limit, rsp_tdata[32]);
               if (rsp_tdata[33] !== want.tilt_limit)
                  report_mismatch("tilt clamped", want.tilt_limit, rsp_tdata[33]);
               if (rsp_tdata[39:34] !== '0)
                  report_mismatch("padding", 0, rsp_tdata[39:34]);
               if (want.pan_limit || want.tilt_limit)
                  n_clamped++;
            end
         end
         if (rsp_gap > 0) begin
            rsp_gap--;
            rsp_tready <= 1'b0;
         end else if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
            rsp_gap = $urandom_range(1, 19) - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   task automatic push_frame(input logic trk, input int x, input int y);
      frame_type f;
      f.tracking = trk;
      f.x = x[11:0];
      f.y = y[11:0];
      frames_pending.push_back(f);
   endtask

   // Mostly a wandering target tracked frame after frame, with holds and jumps.
   task automatic push_random_frame();
      int r;
      r = $urandom_range(0, 99);
      if (r < 10) begin
         push_frame(1'b0, $urandom_range(0, 4095), $urandom_range(0, 4095));
      end else if (r < 22) begin
         push_frame(1'b1, $urandom_range(0, 4095), $urandom_range(0, 4095));
      end else begin
         if ($urandom_range(0, 31) == 0) begin
            wander_x = int'(CENTER_X);
            wander_y = int'(CENTER_Y);
         end
         wander_x = wander_x + int'($urandom_range(0, 40)) - 20;
         wander_y = wander_y + int'($urandom_range(0, 40)) - 20;
         if (wander_x < 0) wander_x = 0;
         if (wander_x > 4095) wander_x = 4095;
         if (wander_y < 0) wander_y = 0;
         if (wander_y > 4095) wander_y = 4095;
         push_frame(1'b1, wander_x, wander_y);
      end
   endtask

   // Waits until every frame is taken and answered.
   task automatic drain();
      do @(negedge clock);
      while (frames_pending.size() != 0 || req_tvalid || angles_expected.size() != 0);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_csr(input logic [3:0] index, input logic [15:0] data);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data <= data;
      do @(posedge clock);
      while (!csr_ready);
      if (index <= CSR_TILT_HIGH_LIMIT)
         cfg_reg[index] = data;
      n_writes++;
      csr_valid <= 1'b0;
   endtask

   function automatic logic [15:0] random_gain();
      int r;
      r = $urandom_range(0, 9);
      if (r < 5)
         return 16'(int'($urandom_range(0, 4096)) - 2048);
      else if (r < 8)
         return 16'($urandom_range(0, 65535));
      case ($urandom_range(0, 2))
         0: return 16'h7fff;
         1: return 16'h8000;
         default: return 16'h0000;
      endcase
   endfunction

   task automatic random_limits(input logic [3:0] lo_index, input logic [3:0] hi_index);
      int r;
      r = $urandom_range(0, 99);
      if (r < 15) begin
         write_csr(lo_index, 16'($urandom_range(23041, 46080)));
         write_csr(hi_index, 16'($urandom_range(0, 23039)));
      end else if (r < 30) begin
         write_csr(lo_index, 16'd0);
         write_csr(hi_index, 16'd46080);
      end else begin
         write_csr(lo_index, 16'($urandom_range(0, 23040)));
         write_csr(hi_index, 16'($urandom_range(23040, 46080)));
      end
   endtask

   task automatic random_settings();
      write_csr(CSR_PAN_P_GAIN, random_gain());
      write_csr(CSR_TILT_P_GAIN, random_gain());
      write_csr(CSR_PAN_D_GAIN, random_gain());
      write_csr(CSR_TILT_D_GAIN, random_gain());
      random_limits(CSR_PAN_LOW_LIMIT, CSR_PAN_HIGH_LIMIT);
      random_limits(CSR_TILT_LOW_LIMIT, CSR_TILT_HIGH_LIMIT);
      if ($urandom_range(0, 3) == 0)
         write_csr(4'($urandom_range(8, 15)), 16'($urandom_range(0, 65535)));
      n_settings++;
   endtask

   initial begin
      int phase_pct [LAST_PHASE];
      int n;
      phase_pct = '{25, 0, 40, 10, 60, 25, 15, 0};
      cfg_reg[CSR_PAN_P_GAIN] = '0;
      cfg_reg[CSR_TILT_P_GAIN] = '0;
      cfg_reg[CSR_PAN_D_GAIN] = '0;
      cfg_reg[CSR_TILT_D_GAIN] = '0;
      cfg_reg[CSR_PAN_LOW_LIMIT] = PAN_LOW_LIMIT_RESET;
      cfg_reg[CSR_PAN_HIGH_LIMIT] = PAN_HIGH_LIMIT_RESET;
      cfg_reg[CSR_TILT_LOW_LIMIT] = TILT_LOW_LIMIT_RESET;
      cfg_reg[CSR_TILT_HIGH_LIMIT] = TILT_HIGH_LIMIT_RESET;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Reset settings: zero gains leave the angles where they are.
      idle_pct = 20;
      push_frame(1'b0, 320, 240);
      push_frame(1'b1, 320, 240);
      push_frame(1'b1, 0, 0);
      push_frame(1'b1, 4095, 4095);
      drain();

      // Moderate gains, probing both edges of the dead zone on each axis.
      write_csr(CSR_PAN_P_GAIN, 16'd4096);
      write_csr(CSR_TILT_P_GAIN, -16'sd4096);
      write_csr(CSR_PAN_D_GAIN, 16'd2048);
      write_csr(CSR_TILT_D_GAIN, -16'sd1024);
      n_settings++;
      push_frame(1'b1, 309, 229);
      push_frame(1'b1, 310, 230);
      push_frame(1'b1, 330, 250);
      push_frame(1'b1, 331, 251);
      push_frame(1'b1, 0, 4095);
      push_frame(1'b1, 4095, 0);
      push_frame(1'b0, 4095, 4095);
      push_frame(1'b1, 331, 251);
      drain();

      // Extreme gains against the widest limits.
      write_csr(CSR_PAN_P_GAIN, 16'h7fff);
      write_csr(CSR_TILT_P_GAIN, 16'h8000);
      write_csr(CSR_PAN_D_GAIN, 16'h7fff);
      write_csr(CSR_TILT_D_GAIN, 16'h8000);
      write_csr(CSR_PAN_LOW_LIMIT, 16'd0);
      write_csr(CSR_PAN_HIGH_LIMIT, 16'd46080);
      write_csr(CSR_TILT_LOW_LIMIT, 16'd0);
      write_csr(CSR_TILT_HIGH_LIMIT, 16'd46080);
      n_settings++;
      push_frame(1'b1, 4095, 4095);
      push_frame(1'b1, 0, 0);
      push_frame(1'b1, 0, 4095);
      drain();

      // Crossed limits; the hold frame must return the stale angles unclamped.
      write_csr(CSR_PAN_LOW_LIMIT, 16'd30000);
      write_csr(CSR_PAN_HIGH_LIMIT, 16'd10000);
      write_csr(CSR_TILT_LOW_LIMIT, 16'd46080);
      write_csr(CSR_TILT_HIGH_LIMIT, 16'd0);
      write_csr(CSR_UNUSED_INDEX, 16'hffff);
      n_settings++;
      push_frame(1'b0, 320, 240);
      push_frame(1'b1, 320, 240);
      push_frame(1'b1, 4095, 0);
      push_frame(1'b1, 0, 4095);
      drain();

      for (int ph = 0; ph < LAST_PHASE; ph++) begin
         random_settings();
         idle_pct = phase_pct[ph];
         for (n = 0; n < 85; n++) begin
            // Once, hold the sender back until the pipeline is empty mid-phase.
            if (ph == 3 && n == 40)
               drain();
            push_random_frame();
         end
         drain();
      end

      repeat (10) @(negedge clock);
      $display("Covered %0d frames (%0d holding), %0d responses, %0d with a clamped axis,",
               n_frames, n_hold, n_results, n_clamped);
      $display("and %0d register writes over %0d gain and limit settings.",
               n_writes, n_settings);
      if (errors == 0)
         $display("** pan_tilt_pd_tracker: PASSED **");
      else
         $display("** pan_tilt_pd_tracker: FAILED **");
      $finish;
   end

   initial begin
      #5ms;
      $display("Timed out with %0d responses outstanding.", angles_expected.size());
      $display("** pan_tilt_pd_tracker: FAILED **");
      $finish;
   end

endmodule

// File: pan_tilt_pd_tracker.f
design/ptpd_pkg.sv
design/pan_tilt_pd_tracker.sv
design/ptpd_checker.sv
sim/testbench.sv
